// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted
`define PITT_ASSERT_HOLDS(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off while reset is asserted
`define PITT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pitt_pkg.sv =====
package pitt_pkg;

	// Store depths
	localparam int MAX_VERTICES_DEF  = 256;
	localparam int MAX_TRIANGLES_DEF = 256;

	// Field widths
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 8;
	localparam int COORD_W    = 16;
	localparam int VNUM_W     = 8;
	localparam int CNT_REG_W  = 9;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Request codes
	typedef enum logic [OP_W-1:0] {
		OP_VTX_WR = 2'd0,
		OP_TRI_WR = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRI_COUNT = 2'd0,
		REG_EDGE_TOL  = 2'd1
	} reg_idx_t;

	// Query sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} seq_state_t;

	// Vertex entry: x in the low half, y in the high half
	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vtx_t;

	// Triangle entry: a in the low byte, c in the high byte
	typedef struct packed {
		logic [VNUM_W-1:0] c;
		logic [VNUM_W-1:0] b;
		logic [VNUM_W-1:0] a;
	} tri_t;

	// Status from the edge test pipeline
	typedef struct packed {
		logic pend;
		logic hit_v;
		logic hit;
	} eval_stat_t;

endpackage

// ===== hdl/pitt_vtx_mem.sv =====
module pitt_vtx_mem #(
	parameter int DEPTH = pitt_pkg::MAX_VERTICES_DEF,
	parameter int AW    = $clog2(pitt_pkg::MAX_VERTICES_DEF)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  pitt_pkg::vtx_t wdata,
	input  logic [AW-1:0]  raddr0,
	input  logic [AW-1:0]  raddr1,
	output pitt_pkg::vtx_t rdata0,
	output pitt_pkg::vtx_t rdata1
);
	import pitt_pkg::*;

	vtx_t mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read two entries, data registered
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ===== hdl/pitt_tri_mem.sv =====
module pitt_tri_mem #(
	parameter int DEPTH = pitt_pkg::MAX_TRIANGLES_DEF,
	parameter int AW    = $clog2(pitt_pkg::MAX_TRIANGLES_DEF)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  pitt_pkg::tri_t wdata,
	input  logic [AW-1:0]  raddr,
	output pitt_pkg::tri_t rdata
);
	import pitt_pkg::*;

	tri_t mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, data registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pitt_edge_eval.sv =====
module pitt_edge_eval (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_v,
	input  logic                       in_bad,
	input  pitt_pkg::vtx_t             va,
	input  pitt_pkg::vtx_t             vb,
	input  pitt_pkg::vtx_t             vc,
	input  pitt_pkg::vtx_t             pt,
	input  logic [pitt_pkg::TOL_W-1:0] tol,
	output pitt_pkg::eval_stat_t       stat
);
	import pitt_pkg::*;

	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;
	localparam int EW = PW + 1;
	localparam int OW = EW + 1;
	localparam int SW = EW + 2;

	function automatic logic signed [DW-1:0] csub(input logic signed [COORD_W-1:0] l,
		input logic signed [COORD_W-1:0] r);
		csub = DW'(l) - DW'(r);
	endfunction

	// Orient an edge value by the sign of D and check it against -tol
	function automatic logic edge_ok(input logic signed [EW-1:0] e, input logic neg,
		input logic [TOL_W-1:0] t);
		logic signed [OW-1:0] oe;
		logic signed [SW-1:0] s;
		oe = neg ? -OW'(e) : OW'(e);
		s  = SW'(oe) + SW'($signed({1'b0, t}));
		edge_ok = !s[SW-1];
	endfunction

	logic v_s1, v_s2, v_s3;
	logic bad_s1, bad_s2;
	logic hit_s3;
	logic signed [DW-1:0] bax_s1, bay_s1, cax_s1, cay_s1;
	logic signed [DW-1:0] apx_s1, apy_s1, bpx_s1, bpy_s1, cpx_s1, cpy_s1;
	logic signed [PW-1:0] md0_s2, md1_s2, m1a_s2, m1b_s2, m2a_s2, m2b_s2, m3a_s2, m3b_s2;
	logic signed [EW-1:0] det_d, det_e1, det_e2, det_e3;
	logic neg_d, hit_d;

	// Advance valid tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: coordinate differences
	always_ff @(posedge clk) begin
		bad_s1 <= in_bad;
		bax_s1 <= csub(vb.x, va.x);
		bay_s1 <= csub(vb.y, va.y);
		cax_s1 <= csub(vc.x, va.x);
		cay_s1 <= csub(vc.y, va.y);
		apx_s1 <= csub(va.x, pt.x);
		apy_s1 <= csub(va.y, pt.y);
		bpx_s1 <= csub(vb.x, pt.x);
		bpy_s1 <= csub(vb.y, pt.y);
		cpx_s1 <= csub(vc.x, pt.x);
		cpy_s1 <= csub(vc.y, pt.y);
	end

	// Stage 2: cross products
	always_ff @(posedge clk) begin
		bad_s2 <= bad_s1;
		md0_s2 <= bax_s1 * cay_s1;
		md1_s2 <= bay_s1 * cax_s1;
		m1a_s2 <= bpx_s1 * cpy_s1;
		m1b_s2 <= bpy_s1 * cpx_s1;
		m2a_s2 <= cpx_s1 * apy_s1;
		m2b_s2 <= cpy_s1 * apx_s1;
		m3a_s2 <= apx_s1 * bpy_s1;
		m3b_s2 <= apy_s1 * bpx_s1;
	end

	// Stage 3: determinants, orientation and tolerance check
	always_comb begin
		det_d  = EW'(md0_s2) - EW'(md1_s2);
		det_e1 = EW'(m1a_s2) - EW'(m1b_s2);
		det_e2 = EW'(m2a_s2) - EW'(m2b_s2);
		det_e3 = EW'(m3a_s2) - EW'(m3b_s2);
		neg_d  = det_d[EW-1];
		hit_d  = !bad_s2 && (det_d != '0) && edge_ok(det_e1, neg_d, tol)
			&& edge_ok(det_e2, neg_d, tol) && edge_ok(det_e3, neg_d, tol);
	end

	always_ff @(posedge clk) begin
		hit_s3 <= hit_d;
	end

	assign stat.pend  = v_s1 | v_s2;
	assign stat.hit_v = v_s3;
	assign stat.hit   = hit_s3;

endmodule

// ===== hdl/point_in_triangulation_test_top.sv =====
// Channel   Signals                                         Handshake
// request   operation slot_index coord_x coord_y vertex_*   start high while busy low
// result    inside_res                                      done high for one cycle
// config    cfg_index cfg_data                              cfg_wen high, no wait
//
// A write request gives no result.
// A query passes the N triangles in use through the edge test pipeline:
// each triangle needs three vertex reads and the vertex store has two read ports, so
// port 0 reads a and then c, and a new triangle is issued only while ph_q is low.
// Reset clears the registers and the sequencer; both stores hold garbage until written.
// The result cannot be stalled; a new request is taken in the cycle done is shown.
module point_in_triangulation_test_top #(
	parameter int MAX_VERTICES  = pitt_pkg::MAX_VERTICES_DEF,
	parameter int MAX_TRIANGLES = pitt_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pitt_pkg::OP_W-1:0]       operation,
	input  logic [pitt_pkg::SLOT_W-1:0]     slot_index,
	input  logic signed [pitt_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pitt_pkg::COORD_W-1:0] coord_y,
	input  logic [pitt_pkg::VNUM_W-1:0]     vertex_a,
	input  logic [pitt_pkg::VNUM_W-1:0]     vertex_b,
	input  logic [pitt_pkg::VNUM_W-1:0]     vertex_c,
	output logic                            done,
	output logic                            inside_res,
	input  logic                            cfg_wen,
	input  logic [pitt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pitt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pitt_pkg::*;

	localparam int VA_W  = $clog2(MAX_VERTICES);
	localparam int TA_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

	seq_state_t state_q, state_d;
	logic [CNT_REG_W-1:0] tri_count_q;
	logic [TOL_W-1:0] edge_tol_q;
	logic [CNT_W-1:0] idx_q, lim_q, lim_d;
	logic ph_q;
	vtx_t pt_q;
	logic hit_q, done_q, inside_q;
	logic accept, q_start, tri_issue, report, pipe_empty;
	logic vtx_we, tri_we;
	tri_t tri_wdata, tri_rd;
	vtx_t vtx_wdata, vrd0, vrd1;
	logic [VA_W-1:0] vaddr0, vaddr1;
	logic trv_s1;
	logic v_s2, bad_s2, bad_d;
	logic [VNUM_W-1:0] c_s2;
	logic v_s3, bad_s3;
	vtx_t a_s3, b_s3;
	eval_stat_t stat;

	assign accept = start && !busy;
	assign vtx_we = accept && (operation == OP_VTX_WR) && (32'(slot_index) < MAX_VERTICES);
	assign tri_we = accept && (operation == OP_TRI_WR) && (32'(slot_index) < MAX_TRIANGLES);
	assign vtx_wdata = '{y: coord_y, x: coord_x};
	assign tri_wdata = '{c: vertex_c, b: vertex_b, a: vertex_a};

	// Clamp the triangle count to the store depth
	assign lim_d = (32'(tri_count_q) > MAX_TRIANGLES) ? CNT_W'(MAX_TRIANGLES)
		: CNT_W'(tri_count_q);

	// Latch configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_count_q <= '0;
			edge_tol_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TRI_COUNT: tri_count_q <= cfg_data[CNT_REG_W-1:0];
				REG_EDGE_TOL:  edge_tol_q  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		q_start   = 1'b0;
		tri_issue = 1'b0;
		report    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_QUERY)) begin
					q_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!ph_q) begin
					if (idx_q < lim_q) begin
						tri_issue = 1'b1;
					end else begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					report  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ph_q     <= 1'b0;
			idx_q    <= '0;
			lim_q    <= '0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= report;
			if (report) begin
				inside_q <= hit_q;
			end
			if (q_start) begin
				ph_q  <= 1'b0;
				idx_q <= '0;
				lim_q <= lim_d;
				hit_q <= 1'b0;
			end else begin
				ph_q <= !ph_q;
				if (tri_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (stat.hit_v && stat.hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Hold the query point
	always_ff @(posedge clk) begin
		if (q_start) begin
			pt_q <= vtx_wdata;
		end
	end

	// Advance read tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trv_s1 <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			trv_s1 <= tri_issue;
			v_s2   <= trv_s1;
			v_s3   <= v_s2;
		end
	end

	// Flag vertex numbers beyond the vertex store
	assign bad_d = (32'(tri_rd.a) >= MAX_VERTICES) || (32'(tri_rd.b) >= MAX_VERTICES)
		|| (32'(tri_rd.c) >= MAX_VERTICES);

	// Carry vertex c and the A, B coordinates between reads
	always_ff @(posedge clk) begin
		c_s2   <= tri_rd.c;
		bad_s2 <= bad_d;
		a_s3   <= vrd0;
		b_s3   <= vrd1;
		bad_s3 <= bad_s2;
	end

	// Port 0 reads a, then c in the next cycle; port 1 reads b
	assign vaddr0 = v_s2 ? VA_W'(c_s2) : VA_W'(tri_rd.a);
	assign vaddr1 = VA_W'(tri_rd.b);

	assign pipe_empty = !trv_s1 && !v_s2 && !v_s3 && !stat.pend && !stat.hit_v;

	pitt_tri_mem #(
		.DEPTH (MAX_TRIANGLES),
		.AW    (TA_W)
	) u_tri_mem (
		.clk   (clk),
		.we    (tri_we),
		.waddr (TA_W'(slot_index)),
		.wdata (tri_wdata),
		.raddr (idx_q[TA_W-1:0]),
		.rdata (tri_rd)
	);

	pitt_vtx_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (VA_W)
	) u_vtx_mem (
		.clk    (clk),
		.we     (vtx_we),
		.waddr  (VA_W'(slot_index)),
		.wdata  (vtx_wdata),
		.raddr0 (vaddr0),
		.raddr1 (vaddr1),
		.rdata0 (vrd0),
		.rdata1 (vrd1)
	);

	pitt_edge_eval u_edge_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (v_s3),
		.in_bad (bad_s3),
		.va     (a_s3),
		.vb     (b_s3),
		.vc     (vrd0),
		.pt     (pt_q),
		.tol    (edge_tol_q),
		.stat   (stat)
	);

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign inside_res = inside_q;

endmodule

// ===== hdl/pitt_checker.sv =====
`include "assert_macros.svh"

module pitt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [pitt_pkg::OP_W-1:0] operation
);
	import pitt_pkg::*;

	logic take_query, take_write;

	assign take_query = start && !busy && (operation == OP_QUERY);
	assign take_write = start && !busy && (operation != OP_QUERY);

	// A result is only shown once the sequencer is back to idle
	`PITT_ASSERT_HOLDS(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	// A result lasts one cycle
	`PITT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done longer than one cycle")
	// A query request starts the scan
	`PITT_ASSERT_NEXT(a_query_busy, clk, arst_n, take_query, busy && !done,
		"query request did not start a scan")
	// A write or unused request neither blocks nor reports
	`PITT_ASSERT_NEXT(a_write_quiet, clk, arst_n, take_write, !busy && !done,
		"write request changed busy or done")

endmodule

bind point_in_triangulation_test_top pitt_checker u_pitt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.operation (operation)
);

// ===== tb/point_in_triangulation_test_top_tb.sv =====
`timescale 1ns / 100ps

module point_in_triangulation_test_top_tb;
	import pitt_pkg::*;

	localparam int NUM_VTX = MAX_VERTICES_DEF;
	localparam int NUM_TRI = MAX_TRIANGLES_DEF;
	localparam int ITEM_TARGET = 650;
	localparam int MISMATCH_SHOWN = 10;

	// Codes the block must ignore
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RSVD_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RSVD_B = 2'd3;

	// Mirror of both stores and registers; holds the queue of expected answers
	class mesh_scoreboard;
		vtx_t vtx_mem[NUM_VTX];
		tri_t tri_mem[NUM_TRI];
		logic [CNT_REG_W-1:0] tri_count;
		logic [TOL_W-1:0] edge_tol;
		bit inside_q[$];
		int unsigned mismatches;

		function new();
			foreach (vtx_mem[i]) vtx_mem[i] = '0;
			foreach (tri_mem[i]) tri_mem[i] = '0;
			tri_count = '0;
			edge_tol = '0;
			mismatches = 0;
		endfunction

		function int unsigned in_use();
			return (tri_count > NUM_TRI) ? NUM_TRI : tri_count;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TRI_COUNT)
				tri_count = data[CNT_REG_W-1:0];
			else if (idx == REG_EDGE_TOL)
				edge_tol = data[TOL_W-1:0];
		endfunction

		// Sign test of the three oriented edge determinants against the slack
		function bit tri_covers(tri_t t, longint px, longint py);
			longint ax, ay, bx, by, cx, cy, d, e1, e2, e3, lim;
			ax = vtx_mem[t.a].x;
			ay = vtx_mem[t.a].y;
			bx = vtx_mem[t.b].x;
			by = vtx_mem[t.b].y;
			cx = vtx_mem[t.c].x;
			cy = vtx_mem[t.c].y;
			d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
			if (d == 0)
				return 1'b0;
			e1 = (bx - px) * (cy - py) - (by - py) * (cx - px);
			e2 = (cx - px) * (ay - py) - (cy - py) * (ax - px);
			e3 = (ax - px) * (by - py) - (ay - py) * (bx - px);
			if (d < 0) begin
				e1 = -e1;
				e2 = -e2;
				e3 = -e3;
			end
			lim = -longint'(edge_tol);
			return (e1 >= lim) && (e2 >= lim) && (e3 >= lim);
		endfunction

		function bit point_in_mesh(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
			bit hit;
			hit = 1'b0;
			for (int i = 0; i < in_use(); i++)
				if (tri_covers(tri_mem[i], x, y))
					hit = 1'b1;
			return hit;
		endfunction

		// Update the mirror for an accepted request; queue the answer of a query
		function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
				logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
				logic [VNUM_W-1:0] a, logic [VNUM_W-1:0] b, logic [VNUM_W-1:0] c);
			case (op)
				OP_VTX_WR: begin
					vtx_mem[slot].x = x;
					vtx_mem[slot].y = y;
				end
				OP_TRI_WR: begin
					tri_mem[slot].a = a;
					tri_mem[slot].b = b;
					tri_mem[slot].c = c;
				end
				OP_QUERY: inside_q.push_back(point_in_mesh(x, y));
				default: ;
			endcase
		endfunction

		function void check_result(logic got);
			bit want;
			if (inside_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOWN)
					$display("%0t: result with no query waiting, inside_res=%b", $time, got);
				return;
			end
			want = inside_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOWN)
					$display("%0t: inside_res mismatch: expected %b, got %b",
						$time, want, got);
			end
		endfunction

		function int unsigned pending();
			return inside_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] operation;
	logic [SLOT_W-1:0] slot_index;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic [VNUM_W-1:0] vertex_a;
	logic [VNUM_W-1:0] vertex_b;
	logic [VNUM_W-1:0] vertex_c;
	logic done;
	logic inside_res;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mesh_scoreboard sb;
	int unsigned idle_pct;
	int unsigned items;
	int unsigned vtx_list[$];
	bit vtx_written[NUM_VTX];

	point_in_triangulation_test_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.slot_index (slot_index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.vertex_a   (vertex_a),
		.vertex_b   (vertex_b),
		.vertex_c   (vertex_c),
		.done       (done),
		.inside_res (inside_res),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every answer in the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(inside_res);
	end

	// Hold the request until the block takes it, with random idle cycles ahead of it
	task automatic issue(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic [VNUM_W-1:0] a, input logic [VNUM_W-1:0] b,
			input logic [VNUM_W-1:0] c);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		slot_index <= slot;
		coord_x <= x;
		coord_y <= y;
		vertex_a <= a;
		vertex_b <= b;
		vertex_c <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(op, slot, x, y, a, b, c);
		if (op != OP_RESERVED)
			items++;
	endtask

	// Send a request with an unused operation code and random fields
	task automatic issue_reserved();
		issue(OP_RESERVED, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			VNUM_W'($urandom), VNUM_W'($urandom), VNUM_W'($urandom));
	endtask

	task automatic put_vertex(input logic [SLOT_W-1:0] slot,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		issue(OP_VTX_WR, slot, x, y, VNUM_W'($urandom), VNUM_W'($urandom),
			VNUM_W'($urandom));
		if (!vtx_written[slot]) begin
			vtx_written[slot] = 1'b1;
			vtx_list.push_back(slot);
		end
	endtask

	task automatic put_triangle(input logic [SLOT_W-1:0] slot, input logic [VNUM_W-1:0] a,
			input logic [VNUM_W-1:0] b, input logic [VNUM_W-1:0] c);
		issue(OP_TRI_WR, slot, COORD_W'($urandom), COORD_W'($urandom), a, b, c);
	endtask

	task automatic ask_point(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		issue(OP_QUERY, SLOT_W'($urandom), x, y, VNUM_W'($urandom), VNUM_W'($urandom),
			VNUM_W'($urandom));
	endtask

	// Drop start and wait until every answer is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write both registers, optionally followed by a write to an unused index
	task automatic program_regs(input int unsigned count_val, input int unsigned tol_val,
			input bit add_unused);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[CNT_REG_W-1:0] = CNT_REG_W'(count_val);
		if ($urandom_range(1))
			data[CFG_DATA_W-1:CNT_REG_W] = '0;
		cfg_wen <= 1'b1;
		cfg_index <= REG_TRI_COUNT;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(REG_TRI_COUNT, data);
		cfg_index <= REG_EDGE_TOL;
		cfg_data <= CFG_DATA_W'(tol_val);
		@(posedge clk);
		sb.set_reg(REG_EDGE_TOL, CFG_DATA_W'(tol_val));
		if (add_unused) begin
			data = CFG_DATA_W'($urandom);
			cfg_index <= $urandom_range(1) ? REG_RSVD_A : REG_RSVD_B;
			cfg_data <= data;
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return COORD_W'(v);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return COORD_W'($urandom_range(2047) - 1024);
		if (r < 55)
			return COORD_W'($urandom_range(16383) - 8192);
		if (r < 90)
			return COORD_W'($urandom);
		case ($urandom_range(3))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic logic [VNUM_W-1:0] pick_vertex();
		return VNUM_W'(vtx_list[$urandom_range(vtx_list.size() - 1)]);
	endfunction

	// Aim most queries at or near a triangle in use so the edge tests see both outcomes
	task automatic random_query();
		int unsigned n;
		int unsigned r;
		longint px, py, jx, jy;
		tri_t t;
		vtx_t v;
		n = sb.in_use();
		r = $urandom_range(99);
		jx = longint'($urandom_range(128)) - 64;
		jy = longint'($urandom_range(128)) - 64;
		if (n > 0 && r < 70) begin
			t = sb.tri_mem[$urandom_range(n - 1)];
			if (r < 50) begin
				px = (longint'(sb.vtx_mem[t.a].x) + sb.vtx_mem[t.b].x + sb.vtx_mem[t.c].x) / 3;
				py = (longint'(sb.vtx_mem[t.a].y) + sb.vtx_mem[t.b].y + sb.vtx_mem[t.c].y) / 3;
			end else begin
				v = sb.vtx_mem[($urandom_range(1)) ? t.a : t.c];
				px = v.x;
				py = v.y;
				jx = jx / 16;
				jy = jy / 16;
			end
			if ($urandom_range(3) == 0) begin
				jx = 0;
				jy = 0;
			end
			ask_point(clamp16(px + jx), clamp16(py + jy));
		end else begin
			ask_point(rand_coord(), rand_coord());
		end
	endtask

	task automatic random_request();
		int unsigned r;
		int unsigned n;
		logic [VNUM_W-1:0] a, b, c;
		r = $urandom_range(99);
		n = sb.in_use();
		a = pick_vertex();
		b = pick_vertex();
		c = pick_vertex();
		if ($urandom_range(19) == 0)
			c = a;
		if (r < 22)
			put_vertex(SLOT_W'($urandom_range(1) ? $urandom_range(15)
				: $urandom_range(NUM_VTX - 1)), rand_coord(), rand_coord());
		else if (r < 40)
			put_triangle(SLOT_W'((n > 0 && $urandom_range(99) < 60) ? $urandom_range(n - 1)
				: $urandom_range(NUM_TRI - 1)), a, b, c);
		else if (r < 95)
			random_query();
		else
			issue_reserved();
	endtask

	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 50)
			return $urandom_range(8, 1);
		if (r < 70)
			return $urandom_range(40, 9);
		if (r < 80)
			return $urandom_range(255, 41);
		if (r < 92)
			return NUM_TRI;
		return $urandom_range(511, NUM_TRI + 1);
	endfunction

	function automatic int unsigned pick_tol();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return 0;
		if (r < 45)
			return 65535;
		if (r < 80)
			return $urandom_range(2000);
		return $urandom_range(65535);
	endfunction

	// Sequence: reset, directed checks, triangle fill, random phases
	initial begin
		int unsigned phase;
		int unsigned phase_len;
		int unsigned cnt;
		int unsigned tol;
		int unsigned idle_cycle[4];
		logic [VNUM_W-1:0] a, b, c;

		sb = new();
		idle_pct = 0;
		items = 0;
		idle_cycle = '{0, 54, 0, 15};
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_VTX_WR;
		slot_index <= '0;
		coord_x <= '0;
		coord_y <= '0;
		vertex_a <= '0;
		vertex_b <= '0;
		vertex_c <= '0;
		cfg_wen <= 1'b0;
		cfg_index <= REG_TRI_COUNT;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No triangles in use: answer must be zero
		ask_point(16'sh0000, 16'sh0000);

		// Extreme and hand-placed vertices
		put_vertex(0, 16'sh8000, 16'sh8000);
		put_vertex(1, 16'sh7fff, 16'sh8000);
		put_vertex(2, 16'sh0000, 16'sh7fff);
		put_vertex(3, 16'sh0000, 16'sh0000);
		put_vertex(4, 16'sh7fff, 16'sh7fff);
		put_vertex(6, 16'sh0100, 16'sh0000);
		put_vertex(7, 16'sh0000, 16'sh0100);
		put_vertex(255, -16'sh0100, 16'sh0100);

		// Small counter-clockwise, collinear, large clockwise, repeated vertex
		put_triangle(0, 3, 6, 7);
		put_triangle(1, 0, 3, 4);
		put_triangle(2, 2, 1, 0);
		put_triangle(3, 255, 255, 255);
		issue_reserved();

		// Point just outside an edge: one unit of slack short, then enough
		drain();
		program_regs(1, 255, 1'b0);
		ask_point(-16'sd1, 16'sd10);
		ask_point(16'sh0000, 16'sh0000);
		ask_point(16'sd85, 16'sd85);
		drain();
		program_regs(1, 256, 1'b0);
		ask_point(-16'sd1, 16'sd10);

		// Collinear triangle never matches, even on its own segment
		drain();
		program_regs(2, 0, 1'b1);
		ask_point(-16'sd256, -16'sd256);
		drain();
		program_regs(3, 0, 1'b0);
		ask_point(-16'sd256, -16'sd256);
		ask_point(16'sh7fff, 16'sh7fff);
		drain();
		program_regs(4, 0, 1'b1);
		ask_point(16'sh8000, 16'sh7fff);

		// Fill the rest of the triangle store so any count is legal
		drain();
		idle_pct = 54;
		for (int s = 4; s < NUM_TRI; s++) begin
			a = pick_vertex();
			b = pick_vertex();
			c = pick_vertex();
			put_triangle(SLOT_W'(s), a, b, c);
			if (s % 8 == 0) begin
				put_vertex(SLOT_W'($urandom_range(NUM_VTX - 1)), rand_coord(), rand_coord());
				random_query();
			end
		end

		// Random phases, each with its own register setting and idle pattern
		phase = 0;
		while (items < ITEM_TARGET) begin
			drain();
			case (phase)
				0: begin
					cnt = NUM_TRI;
					tol = 65535;
				end
				1: begin
					cnt = 511;
					tol = 0;
				end
				default: begin
					cnt = pick_count();
					tol = pick_tol();
				end
			endcase
			program_regs(cnt, tol, $urandom_range(3) == 0);
			idle_pct = idle_cycle[phase % 4];
			phase_len = $urandom_range(60, 30);
			for (int k = 0; k < phase_len && items < ITEM_TARGET; k++) begin
				if ($urandom_range(24) == 0) begin
					start <= 1'b0;
					do @(posedge clk); while (sb.pending() != 0);
				end
				random_request();
			end
			phase++;
		end

		drain();
		repeat (32) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** point_in_triangulation_test_top: PASSED **");
		else
			$display("** point_in_triangulation_test_top: FAILED **");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#40_000_000;
		$display("** point_in_triangulation_test_top: FAILED **");
		$finish;
	end

endmodule
